// ===== hdl/osd_pkg.sv =====
// Shared constants and helpers for the obstacle signed-distance pipeline.
// No dependencies; used by osd_lane, osd_div and the top level in this folder.
`timescale 1ns / 1ps
`default_nettype none
package osd_pkg;

  // Fixed field widths
  localparam int HALF_W    = 31;
  localparam int DIST_W    = 32;
  localparam int GRAD_W    = 16;
  localparam int FRAC_GRAD = 14;
  localparam int Q_BITS    = FRAC_GRAD + 1;
  localparam int OFF_W     = 34;

  // Unit gradient in Q2.14
  localparam logic [GRAD_W-1:0] ONE_GRAD = 16'd16384;

  // 1e-8 expressed in Q.32
  localparam int EPS_Q32 = 43;

  // Shape kinds
  localparam logic SHAPE_SPHERE = 1'b0;
  localparam logic SHAPE_BOX    = 1'b1;

  // Dimension register codes
  localparam logic [1:0] DIMS_2D    = 2'd2;
  localparam logic [1:0] DIMS_RESET = 2'd3;

  // Width of the per-axis penetration value
  function automatic int q_width(input int cw);
    return ((cw > HALF_W) ? cw : HALF_W) + 1;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/osd_lane.sv =====
// One axis lane: difference, magnitude, box penetration and exact square.
// Depends on osd_pkg. Four register stages, all advanced by en.
`timescale 1ns / 1ps
`default_nettype none
module osd_lane #(
  parameter int CW = 32,
  localparam int QW = osd_pkg::q_width(CW)
) (
  input  wire                         clk,
  input  wire                         en,
  input  wire        [CW-1:0]         point,
  input  wire        [CW-1:0]         center,
  input  wire        [osd_pkg::HALF_W-1:0] half,
  input  wire                         kind,
  output logic       [CW-1:0]         v,
  output logic       [2*CW-1:0]       sq,
  output logic signed [QW-1:0]        q,
  output logic                        neg,
  output logic                        pos
);

  localparam int LO = (CW + 1) / 2;
  localparam int HW = CW - LO;
  localparam int PW = 2 * CW;

  logic signed [CW:0]             d1;
  logic [osd_pkg::HALF_W-1:0]     half1;
  logic                           kind1;

  logic [CW:0]                    mag_w;
  logic [CW-1:0]                  mag_c;
  logic signed [QW-1:0]           q_c;
  logic                           neg_c;
  logic                           pos_c;
  logic [CW-1:0]                  v_c;

  logic [CW-1:0]                  v2;
  logic signed [QW-1:0]           q2;
  logic                           neg2;
  logic                           pos2;

  logic [2*LO-1:0]                ll3;
  logic [HW+LO-1:0]               hl3;
  logic [2*HW-1:0]                hh3;
  logic [CW-1:0]                  v3;
  logic signed [QW-1:0]           q3;
  logic                           neg3;
  logic                           pos3;

  // Take the coordinate difference
  always_ff @(posedge clk) begin
    if (en) begin
      d1    <= $signed({point[CW-1], point}) - $signed({center[CW-1], center});
      half1 <= half;
      kind1 <= kind;
    end
  end

  // Form magnitude, penetration and the value to square
  always_comb begin
    neg_c = d1[CW];
    mag_w = neg_c ? (~d1 + 1'b1) : d1;
    mag_c = mag_w[CW-1:0];
    q_c   = $signed({{(QW-CW){1'b0}}, mag_c})
          - $signed({{(QW-osd_pkg::HALF_W){1'b0}}, half1});
    pos_c = !q_c[QW-1] && (q_c != '0);
    if (kind1 == osd_pkg::SHAPE_SPHERE) begin
      v_c = mag_c;
    end else if (pos_c) begin
      v_c = q_c[CW-1:0];
    end else begin
      v_c = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v2   <= v_c;
      q2   <= q_c;
      neg2 <= neg_c;
      pos2 <= pos_c;
    end
  end

  // Split the square into partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll3  <= v2[LO-1:0] * v2[LO-1:0];
      hl3  <= v2[CW-1:LO] * v2[LO-1:0];
      hh3  <= v2[CW-1:LO] * v2[CW-1:LO];
      v3   <= v2;
      q3   <= q2;
      neg3 <= neg2;
      pos3 <= pos2;
    end
  end

  // Combine partial products
  always_ff @(posedge clk) begin
    if (en) begin
      sq  <= {hh3, {(2*LO){1'b0}}}
           + {{(HW-1){1'b0}}, hl3, {(LO+1){1'b0}}}
           + {{(PW-2*LO){1'b0}}, ll3};
      v   <= v3;
      q   <= q3;
      neg <= neg3;
      pos <= pos3;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/osd_sqrt.sv =====
// Pipelined digit-by-digit square root, rounded to nearest, one root bit per stage.
// Depends on osd_pkg only by convention; carries a side payload alongside.
`timescale 1ns / 1ps
`default_nettype none
module osd_sqrt #(
  parameter int RW     = 33,
  parameter int SIDE_W = 8
) (
  input  wire               clk,
  input  wire               en,
  input  wire  [2*RW-1:0]   s,
  input  wire  [SIDE_W-1:0] side_in,
  output logic [RW:0]       root,
  output logic [SIDE_W-1:0] side_out
);

  logic [RW+1:0]     rem_st [RW];
  logic [RW-1:0]     r_st   [RW];
  logic [2*RW-1:0]   s_st   [RW-1];
  logic [SIDE_W-1:0] sd_st  [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [RW+1:0]     rem_in;
    logic [RW-1:0]     r_in;
    logic [2*RW-1:0]   s_in;
    logic [SIDE_W-1:0] sd_in;
    logic [RW+3:0]     rem_sh;
    logic [RW+3:0]     trial;
    logic [RW+3:0]     diff;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_in = '0;
      assign r_in   = '0;
      assign s_in   = s;
      assign sd_in  = side_in;
    end else begin : g_next
      assign rem_in = rem_st[j-1];
      assign r_in   = r_st[j-1];
      assign s_in   = s_st[j-1];
      assign sd_in  = sd_st[j-1];
    end

    // Bring down two bits and try the next root bit
    assign rem_sh = {rem_in, s_in[2*RW-1 -: 2]};
    assign trial  = {2'b00, r_in, 2'b01};
    assign ge     = rem_sh >= trial;
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_st[j] <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
        r_st[j]   <= {r_in[RW-2:0], ge};
        sd_st[j]  <= sd_in;
      end
    end

    if (j < RW - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (en) begin
          s_st[j] <= {s_in[2*RW-3:0], 2'b00};
        end
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_st[RW-1] > {2'b00, r_st[RW-1]}) begin
        root <= {1'b0, r_st[RW-1]} + 1'b1;
      end else begin
        root <= {1'b0, r_st[RW-1]};
      end
      side_out <= sd_st[RW-1];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/osd_div.sv =====
// Pipelined restoring divider for one gradient component: round(num * 2^14 / den).
// Depends on osd_pkg. One setup stage, then one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module osd_div #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 34
) (
  input  wire                          clk,
  input  wire                          en,
  input  wire  [NUM_W-1:0]             num,
  input  wire  [DEN_W-1:0]             den,
  output logic [osd_pkg::Q_BITS-1:0]   quot
);

  localparam int QB = osd_pkg::Q_BITS;
  localparam int FG = osd_pkg::FRAC_GRAD;
  localparam int NW = NUM_W + FG + 1;

  logic [NW-1:0]    n_c;
  logic [DEN_W-1:0] rem_st [QB];
  logic [QB-1:0]    low_st [QB];
  logic [DEN_W-1:0] den_st [QB];
  logic [QB-1:0]    quo_st [QB];

  // Scaled numerator plus half the divisor for rounding
  assign n_c = {1'b0, num, {FG{1'b0}}} + {{(NW-DEN_W+1){1'b0}}, den[DEN_W-1:1]};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_st[0] <= {{(DEN_W-NUM_W){1'b0}}, n_c[NW-1:QB]};
      low_st[0] <= n_c[QB-1:0];
      den_st[0] <= den;
      quo_st[0] <= '0;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_step
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    logic           ge;

    // Shift in the next numerator bit and subtract when it fits
    assign sh   = {rem_st[i-1], low_st[i-1][QB-1]};
    assign ge   = sh >= {1'b0, den_st[i-1]};
    assign diff = sh - {1'b0, den_st[i-1]};

    if (i < QB) begin : g_mid
      always_ff @(posedge clk) begin
        if (en) begin
          rem_st[i] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
          low_st[i] <= {low_st[i-1][QB-2:0], 1'b0};
          den_st[i] <= den_st[i-1];
          quo_st[i] <= {quo_st[i-1][QB-2:0], ge};
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en) begin
          quot <= {quo_st[i-1][QB-2:0], ge};
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/obstacle_signed_distance.sv =====
// Throughput: one request per cycle while the output is taken; the
// square-root pipeline (COORD_WIDTH + 2 stages) and the 16-stage gradient
// dividers set the depth, not the rate.
// The pipeline holds only when its last stage is full and the output is not taken.
// Reset: synchronous; clears all valid flags and sets dims to 3 (3D).
// Top level: three axis lanes, merge, square root, three dividers; uses osd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module obstacle_signed_distance #(
  parameter int COORD_WIDTH = 32
) (
  input  wire         clk,
  input  wire         rst,
  // point_x, point_y, point_z, center_x, center_y, center_z,
  // half_x, half_y, half_z, radius, margin (lowest first), zero padded
  input  wire  [((6*COORD_WIDTH+5*osd_pkg::HALF_W+7)/8)*8-1:0] s_axis_tdata,
  // shape_kind
  input  wire  [0:0]  s_axis_tuser,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // distance, grad_x, grad_y, grad_z (lowest first)
  output logic [79:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_wdata
);

  localparam int CW      = COORD_WIDTH;
  localparam int HW      = osd_pkg::HALF_W;
  localparam int QW      = osd_pkg::q_width(CW);
  localparam int RW      = CW + 1;
  localparam int SW      = 2 * RW;
  localparam int OW      = osd_pkg::OFF_W;
  localparam int QB      = osd_pkg::Q_BITS;
  localparam int GW      = osd_pkg::GRAD_W;
  localparam int SIDE_W  = 3 * CW + 10 + OW;
  localparam int LANE_LAT = 4;
  localparam int DIV_LAT = QB + 1;
  localparam int PIPE    = LANE_LAT + 1 + (RW + 1) + DIV_LAT;
  localparam int DW      = ((RW + 1 > OW) ? RW + 1 : OW) + 2;

  typedef struct packed {
    logic [31:0] distance;
    logic        kind;
    logic        outside;
    logic [1:0]  kstar;
    logic [2:0]  neg;
    logic [2:0]  pos;
  } ctl_t;

  logic              en;
  logic [PIPE-1:0]   vld;
  logic [1:0]        dims;
  logic              is3d;

  logic [CW-1:0]     l_v   [3];
  logic [2*CW-1:0]   l_sq  [3];
  logic signed [QW-1:0] l_q [3];
  logic [2:0]        l_neg;
  logic [2:0]        l_pos;

  logic [HW-1:0]     rad_d  [LANE_LAT];
  logic [HW-1:0]     mar_d  [LANE_LAT];
  logic              kind_d [LANE_LAT];

  logic [SW-1:0]     sum_c;
  logic signed [QW-1:0] m_c;
  logic [1:0]        ks_c;
  logic [2:0]        pos_c;
  logic              out_c;
  logic [31:0]       mneg;
  logic signed [OW-1:0] off_c;

  logic [SW-1:0]     mg_sum;
  logic [SIDE_W-1:0] mg_side;

  logic [RW:0]       root;
  logic [SIDE_W-1:0] sq_side;
  logic signed [OW-1:0] sq_off;
  logic signed [DW-1:0] dfull;
  logic [31:0]       dsat;
  ctl_t              ctl_c;
  ctl_t              ctl_line [DIV_LAT];
  ctl_t              ctl_t_q;

  logic [QB-1:0]     quot [3];
  logic [GW-1:0]     grad [3];

  // Advance unless the last stage is full and the output cannot take it
  assign en            = !(vld[PIPE-1] && m_axis_tvalid && !m_axis_tready);
  assign s_axis_tready = en;
  assign is3d          = (dims != osd_pkg::DIMS_2D);

  // Dimension register
  always_ff @(posedge clk) begin
    if (rst) begin
      dims <= osd_pkg::DIMS_RESET;
    end else if (cfg_we) begin
      dims <= cfg_wdata;
    end
  end

  // Valid flags follow each request down the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE-2:0], s_axis_tvalid};
    end
  end

  // Axis lanes
  for (genvar k = 0; k < 3; k++) begin : g_lane
    osd_lane #(.CW(CW)) u_lane (
      .clk    (clk),
      .en     (en),
      .point  (s_axis_tdata[k*CW +: CW]),
      .center (s_axis_tdata[(3+k)*CW +: CW]),
      .half   (s_axis_tdata[6*CW + k*HW +: HW]),
      .kind   (s_axis_tuser[0]),
      .v      (l_v[k]),
      .sq     (l_sq[k]),
      .q      (l_q[k]),
      .neg    (l_neg[k]),
      .pos    (l_pos[k])
    );
  end

  // Hold radius, margin and kind level with the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      rad_d[0]  <= s_axis_tdata[6*CW + 3*HW +: HW];
      mar_d[0]  <= s_axis_tdata[6*CW + 4*HW +: HW];
      kind_d[0] <= s_axis_tuser[0];
      for (int i = 1; i < LANE_LAT; i++) begin
        rad_d[i]  <= rad_d[i-1];
        mar_d[i]  <= mar_d[i-1];
        kind_d[i] <= kind_d[i-1];
      end
    end
  end

  // Merge lanes: sum of squares, deepest axis, distance offset
  always_comb begin
    sum_c = {2'b00, l_sq[0]} + {2'b00, l_sq[1]}
          + (is3d ? {2'b00, l_sq[2]} : '0) + SW'(osd_pkg::EPS_Q32);
    m_c  = l_q[0];
    ks_c = 2'd0;
    if (l_q[1] > m_c) begin
      m_c  = l_q[1];
      ks_c = 2'd1;
    end
    if (is3d && (l_q[2] > m_c)) begin
      m_c  = l_q[2];
      ks_c = 2'd2;
    end
    pos_c = {is3d & l_pos[2], l_pos[1], l_pos[0]};
    out_c = |pos_c;
    mneg  = m_c[QW-1] ? m_c[31:0] : '0;
    if (kind_d[LANE_LAT-1] == osd_pkg::SHAPE_SPHERE) begin
      off_c = -($signed({3'b000, rad_d[LANE_LAT-1]}) + $signed({3'b000, mar_d[LANE_LAT-1]}));
    end else begin
      off_c = $signed({{2{mneg[31]}}, mneg}) - $signed({3'b000, mar_d[LANE_LAT-1]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mg_sum  <= sum_c;
      mg_side <= {off_c, kind_d[LANE_LAT-1], out_c, ks_c, l_neg, pos_c,
                  l_v[2], l_v[1], l_v[0]};
    end
  end

  osd_sqrt #(.RW(RW), .SIDE_W(SIDE_W)) u_sqrt (
    .clk      (clk),
    .en       (en),
    .s        (mg_sum),
    .side_in  (mg_side),
    .root     (root),
    .side_out (sq_side)
  );

  // Distance from the root, saturated to 32 bits
  always_comb begin
    sq_off = $signed(sq_side[3*CW+10 +: OW]);
    dfull  = $signed({{(DW-RW-1){1'b0}}, root}) + $signed({{(DW-OW){sq_off[OW-1]}}, sq_off});
    if ((&dfull[DW-1:31]) || !(|dfull[DW-1:31])) begin
      dsat = dfull[31:0];
    end else if (dfull[DW-1]) begin
      dsat = 32'h8000_0000;
    end else begin
      dsat = 32'h7FFF_FFFF;
    end
    ctl_c.distance = dsat;
    ctl_c.kind     = sq_side[3*CW+9];
    ctl_c.outside  = sq_side[3*CW+8];
    ctl_c.kstar    = sq_side[3*CW+6 +: 2];
    ctl_c.neg      = sq_side[3*CW+3 +: 3];
    ctl_c.pos      = sq_side[3*CW +: 3];
  end

  // Gradient dividers, one per axis
  for (genvar k = 0; k < 3; k++) begin : g_div
    osd_div #(.NUM_W(CW), .DEN_W(RW + 1)) u_div (
      .clk  (clk),
      .en   (en),
      .num  (sq_side[k*CW +: CW]),
      .den  (root),
      .quot (quot[k])
    );
  end

  // Hold control alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_line[0] <= ctl_c;
      for (int i = 1; i < DIV_LAT; i++) begin
        ctl_line[i] <= ctl_line[i-1];
      end
    end
  end
  assign ctl_t_q = ctl_line[DIV_LAT-1];

  // Select and sign each gradient component
  for (genvar k = 0; k < 3; k++) begin : g_grad
    logic [GW-1:0] gmag;
    always_comb begin
      gmag = ({1'b0, quot[k]} > osd_pkg::ONE_GRAD) ? osd_pkg::ONE_GRAD : {1'b0, quot[k]};
      if ((k == 2) && !is3d) begin
        grad[k] = '0;
      end else if (ctl_t_q.kind == osd_pkg::SHAPE_SPHERE) begin
        grad[k] = ctl_t_q.neg[k] ? (~gmag + 1'b1) : gmag;
      end else if (ctl_t_q.outside) begin
        if (ctl_t_q.pos[k]) begin
          grad[k] = ctl_t_q.neg[k] ? (~gmag + 1'b1) : gmag;
        end else begin
          grad[k] = '0;
        end
      end else if (ctl_t_q.kstar == 2'(k)) begin
        grad[k] = ctl_t_q.neg[k] ? (~osd_pkg::ONE_GRAD + 1'b1) : osd_pkg::ONE_GRAD;
      end else begin
        grad[k] = '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en && vld[PIPE-1]) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[PIPE-1]) begin
      m_axis_tdata <= {grad[2], grad[1], grad[0], ctl_t_q.distance};
    end
  end

endmodule
`default_nettype wire
